FILE: hdl/rtmr_pkg.sv
// Shared types, codes and fixed-point helpers for the 2D Richtmyer flow step.
// No dependencies; all other files but rtmr_ram refer to it by scoped names.
package rtmr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FIX_W     = 32;
	localparam int RATIO_W   = 17;
	localparam int DIM_W     = 7;
	localparam int IDX_W     = 12;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;
	localparam int SLOT_W    = 3;
	localparam int QSEL_W    = 3;
	localparam int DIFF_W    = FIX_W + 1;
	localparam int PROD_W    = DIFF_W + RATIO_W + 1;

	typedef logic signed [FIX_W-1:0] fix_t;

	typedef struct packed {
		fix_t n;
		fix_t px;
		fix_t py;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	typedef struct packed {
		fix_t v;
		logic ovf;
	} sat_t;

	// request codes
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FAULT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DTX  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DTY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd3;

	// read slots: corners sw, se, nw, ne, then the center cell
	localparam logic [SLOT_W-1:0] SLOT_BASE = 3'd4;
	localparam logic [QSEL_W-1:0] Q_LAST    = 3'd7;

	localparam fix_t FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
	localparam fix_t FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

	typedef struct packed {
		logic                main_re;
		logic                mid_re;
		logic                main_we;
		logic                mid_we;
		logic                wr_user;
		logic [SLOT_W-1:0]   slot;
		logic                ph2;
		logic                load_side;
		logic [QSEL_W-1:0]   q;
		logic                div_start;
		logic                mul;
		logic                fin;
		logic                clr_fault;
		logic                rsp_zero;
		logic                rsp_read;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic step_fault;
	} ctrl_stat_t;

	function automatic sat_t sat64(input logic signed [63:0] v);
		sat_t r;
		r.ovf = !((&v[63:FIX_W-1]) || (~|v[63:FIX_W-1]));
		r.v   = r.ovf ? (v[63] ? FIX_MIN : FIX_MAX) : v[FIX_W-1:0];
		return r;
	endfunction

	function automatic fix_t half2(input fix_t a, input fix_t b);
		logic signed [FIX_W:0] s;
		s = (FIX_W+1)'(a) + (FIX_W+1)'(b);
		return s[FIX_W:1];
	endfunction

	function automatic fix_t quarter4(input fix_t a, input fix_t b, input fix_t c,
	                                  input fix_t d);
		logic signed [FIX_W+1:0] s;
		s = (FIX_W+2)'(a) + (FIX_W+2)'(b) + (FIX_W+2)'(c) + (FIX_W+2)'(d);
		return s[FIX_W+1:2];
	endfunction

	function automatic cell_t avg2(input cell_t a, input cell_t b);
		cell_t r;
		r.n  = half2(a.n, b.n);
		r.px = half2(a.px, b.px);
		r.py = half2(a.py, b.py);
		return r;
	endfunction

	function automatic cell_t avg4(input cell_t a, input cell_t b, input cell_t c,
	                               input cell_t d);
		cell_t r;
		r.n  = quarter4(a.n, b.n, c.n, d.n);
		r.px = quarter4(a.px, b.px, c.px, d.px);
		r.py = quarter4(a.py, b.py, c.py, d.py);
		return r;
	endfunction

	function automatic fix_t cell_get(input cell_t c, input logic [1:0] k);
		fix_t r;
		case (k)
			2'd0:    r = c.n;
			2'd1:    r = c.px;
			default: r = c.py;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/rtmr_if.sv
// Valid/ready channel interfaces for requests and results of the flow step.
// Depends on rtmr_pkg for field widths.
interface rtmr_req_if;
	logic                                valid;
	logic                                ready;
	logic [rtmr_pkg::REQ_W-1:0]          req_type;
	logic [rtmr_pkg::IDX_W-1:0]          cell_index;
	logic signed [rtmr_pkg::FIX_W-1:0]   density_in;
	logic signed [rtmr_pkg::FIX_W-1:0]   momentum_x_in;
	logic signed [rtmr_pkg::FIX_W-1:0]   momentum_y_in;

	modport source (output valid, req_type, cell_index, density_in, momentum_x_in,
	                momentum_y_in, input ready);
	modport sink (input valid, req_type, cell_index, density_in, momentum_x_in,
	              momentum_y_in, output ready);
endinterface

interface rtmr_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [rtmr_pkg::FIX_W-1:0]   density_out;
	logic signed [rtmr_pkg::FIX_W-1:0]   momentum_x_out;
	logic signed [rtmr_pkg::FIX_W-1:0]   momentum_y_out;
	logic [rtmr_pkg::STATUS_W-1:0]       status;

	modport source (output valid, density_out, momentum_x_out, momentum_y_out, status,
	                input ready);
	modport sink (input valid, density_out, momentum_x_out, momentum_y_out, status,
	              output ready);
endinterface

FILE: hdl/richtmyer_2d_flow_step.sv
// Top level of the 2D Richtmyer flow step: configuration registers, controller
// and datapath. Depends on rtmr_pkg, rtmr_if, rtmr_ctrl and rtmr_dp.
//
// Usage: one request transaction on req (write cell, read cell, run one time
// step) yields exactly one result transaction on rsp. The block works on one
// request at a time; req.ready is high only while no request is in progress.
// A write, out-of-grid or unused request goes straight to the result state; a
// read first passes a read-response state (registered memory read). A time step
// walks (cols-1)*(rows-1) mid cells, then (cols-2)*(rows-2) interior main cells;
// each cell takes 5 memory reads, 1 capture, 1 side load, 8 quotients on the one
// shared bit-serial 64/32 divider, 1 multiply, 1 sum and 1 write. The divider
// sets the step time. Results stay in the output register while rsp.ready is
// low; no new request is taken until the result transaction completes.
// Reset clears the controller, fault flag and configuration to its defaults;
// the cell memories are not cleared and a cell must be written before it is
// read. Configuration writes belong to idle periods only.
module richtmyer_2d_flow_step #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	rtmr_req_if.sink                         req,
	rtmr_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [rtmr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtmr_pkg::CFG_W-1:0]       cfg_data
);

	localparam int DEPTH   = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW      = rtmr_pkg::DIM_W;
	localparam int COL_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;
	localparam int ROW_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int COL_RST = (MAX_COLS < 64) ? MAX_COLS : 64;
	localparam int ROW_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
	localparam logic [DW-1:0] DIM_MIN = 7'd3;

	logic [rtmr_pkg::RATIO_W-1:0] dtx_q, dty_q;
	logic [DW-1:0]                cols_q, rows_q, v7, cols_new, rows_new;
	rtmr_pkg::ctrl_cmd_t          cmd;
	rtmr_pkg::ctrl_stat_t         stat;
	rtmr_pkg::cell_t              user_cell, rsp_cell;
	logic [ADDR_W-1:0]            addr;

	// clamp grid sizes into the supported range as they are written
	assign v7       = cfg_data[DW-1:0];
	assign cols_new = (v7 < DIM_MIN) ? DIM_MIN : ((v7 > DW'(COL_CAP)) ? DW'(COL_CAP) : v7);
	assign rows_new = (v7 < DIM_MIN) ? DIM_MIN : ((v7 > DW'(ROW_CAP)) ? DW'(ROW_CAP) : v7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtx_q  <= 17'd6554;
			dty_q  <= 17'd6554;
			cols_q <= DW'(COL_RST);
			rows_q <= DW'(ROW_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtmr_pkg::CFG_DTX:  dtx_q  <= cfg_data;
				rtmr_pkg::CFG_DTY:  dty_q  <= cfg_data;
				rtmr_pkg::CFG_COLS: cols_q <= cols_new;
				rtmr_pkg::CFG_ROWS: rows_q <= rows_new;
				default: ;
			endcase
		end
	end

	// write payload goes straight to the main memory in the accept cycle
	assign user_cell = {req.density_in, req.momentum_x_in, req.momentum_y_in};

	rtmr_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_type(req.req_type), .cell_index(req.cell_index),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.status),
		.grid_cols(cols_q), .grid_rows(rows_q),
		.cmd(cmd), .addr(addr), .stat(stat)
	);

	rtmr_dp #(.DEPTH(DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .addr(addr), .user_cell(user_cell),
		.dt_over_dx(dtx_q), .dt_over_dy(dty_q), .stat(stat), .rsp_cell(rsp_cell)
	);

	// hold the result cell until the result transaction completes
	assign rsp.density_out    = rsp_cell.n;
	assign rsp.momentum_x_out = rsp_cell.px;
	assign rsp.momentum_y_out = rsp_cell.py;

endmodule

FILE: hdl/rtmr_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module rtmr_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/rtmr_div.sv
// Serial signed divider: forms a*b, then divides by n one quotient bit a cycle.
// Truncates toward zero, saturates to 32 bits; flags overflow and zero divisor.
module rtmr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rtmr_pkg::fix_t    a,
	input  rtmr_pkg::fix_t    b,
	input  rtmr_pkg::fix_t    n,
	output logic              done,
	output rtmr_pkg::fix_t    quo,
	output logic              ovf
);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_PREP = 4'b0010,
		D_RUN  = 4'b0100,
		D_FIN  = 4'b1000
	} div_state_t;

	div_state_t state_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] mul_w;
	rtmr_pkg::fix_t     n_q;
	logic [31:0]        den_q;
	logic [31:0]        rem_q;
	logic [63:0]        quo_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic               zero_q;
	logic [32:0]        trial;
	logic               take;

	assign mul_w = 64'(a) * 64'(b);
	assign trial = {rem_q, quo_q[63]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			unique case (state_q)
				D_IDLE: if (start) state_q <= D_PREP;
				D_PREP: state_q <= (n_q == '0) ? D_FIN : D_RUN;
				D_RUN:  if (cnt_q == 6'd63) state_q <= D_FIN;
				D_FIN:  state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			prod_q <= mul_w;
			n_q    <= n;
		end
		if (state_q == D_PREP) begin
			den_q  <= n_q[31] ? 32'(-n_q) : 32'(n_q);
			quo_q  <= prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
			rem_q  <= '0;
			cnt_q  <= '0;
			neg_q  <= prod_q[63] ^ n_q[31];
			zero_q <= (n_q == '0);
		end
		if (state_q == D_RUN) begin
			rem_q <= take ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[62:0], take};
			cnt_q <= cnt_q + 6'd1;
		end
	end

	always_comb begin
		done = (state_q == D_FIN);
		if (zero_q) begin
			ovf = 1'b1;
			if (prod_q[63])       quo = rtmr_pkg::FIX_MIN;
			else if (|prod_q)     quo = rtmr_pkg::FIX_MAX;
			else                  quo = '0;
		end else if (neg_q) begin
			ovf = (|quo_q[63:32]) || (quo_q[31] && (|quo_q[30:0]));
			quo = ovf ? rtmr_pkg::FIX_MIN : 32'(-quo_q[31:0]);
		end else begin
			ovf = |quo_q[63:31];
			quo = ovf ? rtmr_pkg::FIX_MAX : quo_q[31:0];
		end
	end

endmodule

FILE: hdl/rtmr_dp.sv
// Datapath: both cell memories, corner and side registers, fluxes, the shared
// divider and the ratio multipliers. Depends on rtmr_pkg, rtmr_ram, rtmr_div.
module rtmr_dp #(
	parameter int DEPTH = 4096,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rtmr_pkg::ctrl_cmd_t               cmd,
	input  logic [ADDR_W-1:0]                 addr,
	input  rtmr_pkg::cell_t                   user_cell,
	input  logic [rtmr_pkg::RATIO_W-1:0]      dt_over_dx,
	input  logic [rtmr_pkg::RATIO_W-1:0]      dt_over_dy,
	output rtmr_pkg::ctrl_stat_t              stat,
	output rtmr_pkg::cell_t                   rsp_cell
);

	localparam int PW = rtmr_pkg::PROD_W;

	rtmr_pkg::cell_t main_rdata, mid_rdata, main_wdata, res_cell;
	rtmr_pkg::cell_t corner_q [5];
	rtmr_pkg::cell_t side_q [4];
	rtmr_pkg::cell_t side_d [4];
	rtmr_pkg::cell_t base_q, rsp_q, sd;
	rtmr_pkg::fix_t  flux_q [4][3];
	rtmr_pkg::fix_t  res_q [3];
	logic signed [PW-1:0] px_s1 [3];
	logic signed [PW-1:0] py_s1 [3];
	rtmr_pkg::sat_t  fin_sat [3];
	logic            rd_v_s1, rd_mid_s1, fault_q;
	logic [rtmr_pkg::SLOT_W-1:0] rd_slot_s1;

	rtmr_pkg::fix_t  op_a, op_b, div_quo, fval;
	logic            div_done, div_ovf, ew, add_n, fovf, fin_ovf;
	logic [1:0]      fk;
	rtmr_pkg::sat_t  nsum;

	rtmr_ram #(.WIDTH(rtmr_pkg::CELL_W), .DEPTH(DEPTH)) u_main_ram (
		.clk(clk), .we(cmd.main_we), .waddr(addr), .wdata(main_wdata),
		.re(cmd.main_re), .raddr(addr), .rdata(main_rdata)
	);

	rtmr_ram #(.WIDTH(rtmr_pkg::CELL_W), .DEPTH(DEPTH)) u_mid_ram (
		.clk(clk), .we(cmd.mid_we), .waddr(addr), .wdata(res_cell),
		.re(cmd.mid_re), .raddr(addr), .rdata(mid_rdata)
	);

	assign res_cell   = {res_q[0], res_q[1], res_q[2]};
	assign main_wdata = cmd.wr_user ? user_cell : res_cell;

	// sides: east, west, north, south of the staggered corner square
	always_comb begin
		side_d[0] = rtmr_pkg::avg2(corner_q[3], corner_q[1]);
		side_d[1] = rtmr_pkg::avg2(corner_q[2], corner_q[0]);
		side_d[2] = rtmr_pkg::avg2(corner_q[3], corner_q[2]);
		side_d[3] = rtmr_pkg::avg2(corner_q[1], corner_q[0]);
	end

	// quotient select: q[2:1] picks the side, q[0] the flux term
	always_comb begin
		sd    = side_q[cmd.q[2:1]];
		ew    = ~cmd.q[2];
		op_a  = (ew || !cmd.q[0]) ? sd.px : sd.py;
		op_b  = (ew && !cmd.q[0]) ? sd.px : sd.py;
		add_n = ew ? ~cmd.q[0] : cmd.q[0];
		fk    = cmd.q[0] ? 2'd2 : 2'd1;
		nsum  = rtmr_pkg::sat64(64'(div_quo) + 64'(sd.n));
		fval  = add_n ? nsum.v : div_quo;
		fovf  = div_ovf | (add_n & nsum.ovf);
	end

	rtmr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.a(op_a), .b(op_b), .n(sd.n),
		.done(div_done), .quo(div_quo), .ovf(div_ovf)
	);

	always_comb begin
		logic signed [PW-1:0] tx, ty;
		fin_ovf = 1'b0;
		for (int k = 0; k < 3; k++) begin
			tx = cmd.ph2 ? (px_s1[k] >>> rtmr_pkg::FRAC_BITS)
			             : (px_s1[k] >>> (rtmr_pkg::FRAC_BITS + 1));
			ty = cmd.ph2 ? (py_s1[k] >>> rtmr_pkg::FRAC_BITS)
			             : (py_s1[k] >>> (rtmr_pkg::FRAC_BITS + 1));
			fin_sat[k] = rtmr_pkg::sat64(64'(rtmr_pkg::cell_get(base_q, 2'(k)))
			                             - 64'(tx) - 64'(ty));
			fin_ovf = fin_ovf | fin_sat[k].ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			fault_q <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.main_re | cmd.mid_re;
			if (cmd.clr_fault) begin
				fault_q <= 1'b0;
			end else if ((div_done && fovf) || (cmd.fin && fin_ovf)) begin
				fault_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_slot_s1 <= cmd.slot;
		rd_mid_s1  <= cmd.mid_re;
		if (rd_v_s1) begin
			corner_q[rd_slot_s1] <= rd_mid_s1 ? mid_rdata : main_rdata;
		end
		if (cmd.load_side) begin
			for (int s = 0; s < 4; s++) side_q[s] <= side_d[s];
			flux_q[0][0] <= side_d[0].px;
			flux_q[1][0] <= side_d[1].px;
			flux_q[2][0] <= side_d[2].py;
			flux_q[3][0] <= side_d[3].py;
			base_q <= cmd.ph2 ? corner_q[4]
			                  : rtmr_pkg::avg4(corner_q[0], corner_q[1], corner_q[2],
			                                   corner_q[3]);
		end
		if (div_done) begin
			flux_q[cmd.q[2:1]][fk] <= fval;
		end
		if (cmd.mul) begin
			for (int k = 0; k < 3; k++) begin
				px_s1[k] <= PW'(rtmr_pkg::DIFF_W'(flux_q[0][k]) - rtmr_pkg::DIFF_W'(flux_q[1][k]))
				            * PW'($signed({1'b0, dt_over_dx}));
				py_s1[k] <= PW'(rtmr_pkg::DIFF_W'(flux_q[2][k]) - rtmr_pkg::DIFF_W'(flux_q[3][k]))
				            * PW'($signed({1'b0, dt_over_dy}));
			end
		end
		if (cmd.fin) begin
			for (int k = 0; k < 3; k++) res_q[k] <= fin_sat[k].v;
		end
		if (cmd.rsp_zero) begin
			rsp_q <= '0;
		end else if (cmd.rsp_read) begin
			rsp_q <= main_rdata;
		end
	end

	assign stat.div_done   = div_done;
	assign stat.step_fault = fault_q;
	assign rsp_cell        = rsp_q;

endmodule

FILE: hdl/rtmr_ctrl.sv
// Controller: request decode, result handshake and the two-sweep step sequencer.
// Depends on rtmr_pkg; drives rtmr_dp through ctrl_cmd_t and a memory address.
module rtmr_ctrl #(
	parameter int DEPTH = 4096,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic [rtmr_pkg::REQ_W-1:0]        req_type,
	input  logic [rtmr_pkg::IDX_W-1:0]        cell_index,
	output logic                              req_ready,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [rtmr_pkg::STATUS_W-1:0]     status,
	input  logic [rtmr_pkg::DIM_W-1:0]        grid_cols,
	input  logic [rtmr_pkg::DIM_W-1:0]        grid_rows,
	output rtmr_pkg::ctrl_cmd_t               cmd,
	output logic [ADDR_W-1:0]                 addr,
	input  rtmr_pkg::ctrl_stat_t              stat
);

	localparam int DW = rtmr_pkg::DIM_W;

	typedef enum logic [10:0] {
		C_IDLE   = 11'b000_0000_0001,
		C_RDRSP  = 11'b000_0000_0010,
		C_RESP   = 11'b000_0000_0100,
		C_RD     = 11'b000_0000_1000,
		C_CAP    = 11'b000_0001_0000,
		C_SIDE   = 11'b000_0010_0000,
		C_QSTART = 11'b000_0100_0000,
		C_QRUN   = 11'b000_1000_0000,
		C_MUL    = 11'b001_0000_0000,
		C_FIN    = 11'b010_0000_0000,
		C_WR     = 11'b100_0000_0000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic               ph2_q, ph2_d, fault_seen_q, fault_seen_d;
	logic [DW-1:0]      i_q, i_d, j_q, j_d, col, row;
	logic [rtmr_pkg::SLOT_W-1:0] slot_q, slot_d, sel;
	logic [rtmr_pkg::QSEL_W-1:0] q_q, q_d;
	logic [rtmr_pkg::STATUS_W-1:0] status_q, status_d;
	logic [2*DW-1:0]    cells;
	logic [2*DW:0]      step_addr;
	logic               idx_ok, dx, dy, last_i, last_j;

	assign cells  = (2*DW)'(grid_cols) * (2*DW)'(grid_rows);
	assign idx_ok = (2*DW)'(cell_index) < cells;
	assign last_i = (i_q == grid_cols - DW'(2));
	assign last_j = (j_q == grid_rows - DW'(2));

	// corner offsets come from the slot bits; the center slot sits at (i, j)
	assign sel = (state_q == C_RD) ? slot_q : rtmr_pkg::SLOT_BASE;
	assign dx  = (sel == rtmr_pkg::SLOT_BASE) ? ph2_q : sel[0];
	assign dy  = (sel == rtmr_pkg::SLOT_BASE) ? ph2_q : sel[1];
	assign col = i_q + DW'(dx) - DW'(ph2_q);
	assign row = j_q + DW'(dy) - DW'(ph2_q);
	assign step_addr = (2*DW+1)'(col) + (2*DW+1)'(row) * (2*DW+1)'(grid_cols);

	assign addr = (state_q == C_IDLE) ? ADDR_W'({{ADDR_W{1'b0}}, cell_index})
	                                  : ADDR_W'({{ADDR_W{1'b0}}, step_addr});

	assign req_ready = (state_q == C_IDLE);
	assign rsp_valid = (state_q == C_RESP);
	assign status    = status_q;

	always_comb begin
		cmd          = '0;
		cmd.q        = q_q;
		cmd.ph2      = ph2_q;
		cmd.slot     = slot_q;
		state_d      = state_q;
		ph2_d        = ph2_q;
		i_d          = i_q;
		j_d          = j_q;
		slot_d       = slot_q;
		q_d          = q_q;
		status_d     = status_q;
		fault_seen_d = fault_seen_q;
		unique case (state_q)
			C_IDLE: begin
				if (req_valid) begin
					cmd.rsp_zero = 1'b1;
					state_d      = C_RESP;
					status_d     = rtmr_pkg::ST_OK;
					unique case (req_type)
						rtmr_pkg::REQ_WRITE: begin
							if (idx_ok) begin
								cmd.main_we = 1'b1;
								cmd.wr_user = 1'b1;
							end else begin
								status_d = rtmr_pkg::ST_RANGE;
							end
						end
						rtmr_pkg::REQ_READ: begin
							if (idx_ok) begin
								cmd.main_re  = 1'b1;
								cmd.rsp_zero = 1'b0;
								state_d      = C_RDRSP;
								status_d     = fault_seen_q ? rtmr_pkg::ST_FAULT
								                            : rtmr_pkg::ST_OK;
							end else begin
								status_d = rtmr_pkg::ST_RANGE;
							end
						end
						rtmr_pkg::REQ_STEP: begin
							cmd.clr_fault = 1'b1;
							ph2_d   = 1'b0;
							i_d     = '0;
							j_d     = '0;
							slot_d  = '0;
							state_d = C_RD;
						end
						default: ;
					endcase
				end
			end
			C_RDRSP: begin
				cmd.rsp_read = 1'b1;
				state_d      = C_RESP;
			end
			C_RESP: begin
				if (rsp_ready) state_d = C_IDLE;
			end
			C_RD: begin
				cmd.mid_re  = ph2_q && (slot_q != rtmr_pkg::SLOT_BASE);
				cmd.main_re = !(ph2_q && (slot_q != rtmr_pkg::SLOT_BASE));
				slot_d      = slot_q + 3'd1;
				if (slot_q == rtmr_pkg::SLOT_BASE) state_d = C_CAP;
			end
			C_CAP: state_d = C_SIDE;
			C_SIDE: begin
				cmd.load_side = 1'b1;
				q_d           = '0;
				state_d       = C_QSTART;
			end
			C_QSTART: begin
				cmd.div_start = 1'b1;
				state_d       = C_QRUN;
			end
			C_QRUN: begin
				if (stat.div_done) begin
					if (q_q == rtmr_pkg::Q_LAST) begin
						state_d = C_MUL;
					end else begin
						q_d     = q_q + 3'd1;
						state_d = C_QSTART;
					end
				end
			end
			C_MUL: begin
				cmd.mul = 1'b1;
				state_d = C_FIN;
			end
			C_FIN: begin
				cmd.fin = 1'b1;
				state_d = C_WR;
			end
			C_WR: begin
				cmd.main_we = ph2_q;
				cmd.mid_we  = !ph2_q;
				slot_d      = '0;
				state_d     = C_RD;
				if (!last_i) begin
					i_d = i_q + DW'(1);
				end else if (!last_j) begin
					i_d = DW'(ph2_q);
					j_d = j_q + DW'(1);
				end else if (!ph2_q) begin
					ph2_d = 1'b1;
					i_d   = DW'(1);
					j_d   = DW'(1);
				end else begin
					status_d     = stat.step_fault ? rtmr_pkg::ST_FAULT : rtmr_pkg::ST_OK;
					fault_seen_d = fault_seen_q | stat.step_fault;
					state_d      = C_RESP;
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= C_IDLE;
			fault_seen_q <= 1'b0;
			ph2_q        <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			slot_q       <= '0;
			q_q          <= '0;
			status_q     <= rtmr_pkg::ST_OK;
		end else begin
			state_q      <= state_d;
			fault_seen_q <= fault_seen_d;
			ph2_q        <= ph2_d;
			i_q          <= i_d;
			j_q          <= j_d;
			slot_q       <= slot_d;
			q_q          <= q_d;
			status_q     <= status_d;
		end
	end

endmodule
